// File: hdl/keuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kruskal edge union-find package
// Shared constants and types for the union-find edge acceptor.
// ----------------------------------------------------------------------------
package keuf_pkg;

    // Width of the saturating cost sum.
    localparam int SUM_W  = 26;
    // Width of the per-root rank.
    localparam int RANK_W = 4;
    // Width of the vertex count register and its value after reset.
    localparam int VC_W   = 11;

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;
    localparam logic [VC_W-1:0]   VC_RESET = 11'd1024;

    // Register word index on the configuration port.
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic accepted;
        logic tree_done;
        logic bad_node;
    } t_res_flags;

endpackage

// File: hdl/keuf_edge_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge request channel
// Valid/ready channel carrying one graph edge per request.
// ----------------------------------------------------------------------------
interface keuf_edge_if #(
    parameter int NODE_W = 10,
    parameter int COST_W = 16
);
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [COST_W-1:0] edge_cost;

    modport source (output valid, from_node, to_node, edge_cost, input ready);
    modport sink   (input valid, from_node, to_node, edge_cost, output ready);
endinterface

// File: hdl/keuf_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel carrying the verdict and tree totals for one edge.
// ----------------------------------------------------------------------------
interface keuf_res_if #(
    parameter int NODE_W = 10,
    parameter int SUM_W  = 26
);
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              tree_done;
    logic              bad_node;
    logic [NODE_W-1:0] edges_in_tree;
    logic [SUM_W-1:0]  total_cost;

    modport source (output valid, accepted, tree_done, bad_node, edges_in_tree,
                    total_cost, input ready);
    modport sink   (input valid, accepted, tree_done, bad_node, edges_in_tree,
                    total_cost, output ready);
endinterface

// File: hdl/keuf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module keuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/keuf_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find walker
// Sequencer that walks parent chains, compresses paths and joins sets.
// ----------------------------------------------------------------------------
module keuf_walker #(
    parameter int MAX_NODES = 1024,
    parameter int COST_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_ready,
    input  logic [$clog2(MAX_NODES)-1:0]         i_from_node,
    input  logic [$clog2(MAX_NODES)-1:0]         i_to_node,
    input  logic [COST_BITS-1:0]                 i_edge_cost,
    input  logic [$clog2(MAX_NODES+1)-1:0]       i_vcount,
    output logic                                 o_res_valid,
    input  logic                                 i_res_take,
    output keuf_pkg::t_res_flags                 o_flags,
    output logic [$clog2(MAX_NODES)-1:0]         o_edges,
    output logic [keuf_pkg::SUM_W-1:0]           o_total
);
    import keuf_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ADD_W  = ((COST_BITS > SUM_W) ? COST_BITS : SUM_W) + 1;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_COMP  = 3'd3;
    localparam logic [2:0] S_UNION = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [NODE_W-1:0]    r_clr, n_clr;
    logic [NODE_W-1:0]    r_b, n_b;
    logic [COST_BITS-1:0] r_cost, n_cost;
    logic [NODE_W-1:0]    r_cur, n_cur;
    logic [NODE_W-1:0]    r_start, n_start;
    logic [NODE_W-1:0]    r_root, n_root;
    logic [RANK_W-1:0]    r_rkroot, n_rkroot;
    logic                 r_deep, n_deep;
    logic                 r_phase, n_phase;
    logic [NODE_W-1:0]    r_ra, n_ra;
    logic [RANK_W-1:0]    r_rka, n_rka;
    logic [NODE_W-1:0]    r_rb, n_rb;
    logic [RANK_W-1:0]    r_rkb, n_rkb;
    logic [NODE_W-1:0]    r_count, n_count;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic                 r_acc, n_acc;
    logic                 r_bad, n_bad;

    logic [NODE_W-1:0]    ram_raddr;
    logic [NODE_W-1:0]    q_par;
    logic [RANK_W-1:0]    q_rank;
    logic                 par_we;
    logic [NODE_W-1:0]    par_waddr, par_wdata;
    logic                 rank_we;
    logic [NODE_W-1:0]    rank_waddr;
    logic [RANK_W-1:0]    rank_wdata;

    logic [CNT_W-1:0]     target;
    logic                 done_now;
    logic                 bad_in;
    logic                 fin;
    logic [NODE_W-1:0]    fin_root;
    logic [RANK_W-1:0]    fin_rank;
    logic [ADD_W-1:0]     sum_wide;

    keuf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent (
        .i_clk  (i_clk),
        .i_we   (par_we),
        .i_waddr(par_waddr),
        .i_wdata(par_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(q_par)
    );

    keuf_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank (
        .i_clk  (i_clk),
        .i_we   (rank_we),
        .i_waddr(rank_waddr),
        .i_wdata(rank_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(q_rank)
    );

    assign target   = (i_vcount != '0) ? i_vcount - CNT_W'(1) : '0;
    assign done_now = CNT_W'(r_count) >= target;
    assign bad_in   = (CNT_W'(i_from_node) >= i_vcount) || (CNT_W'(i_to_node) >= i_vcount);
    assign sum_wide = ADD_W'(r_sum) + ADD_W'(r_cost);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_b      = r_b;
        n_cost   = r_cost;
        n_cur    = r_cur;
        n_start  = r_start;
        n_root   = r_root;
        n_rkroot = r_rkroot;
        n_deep   = r_deep;
        n_phase  = r_phase;
        n_ra     = r_ra;
        n_rka    = r_rka;
        n_rb     = r_rb;
        n_rkb    = r_rkb;
        n_count  = r_count;
        n_sum    = r_sum;
        n_acc    = r_acc;
        n_bad    = r_bad;

        ram_raddr  = r_cur;
        par_we     = 1'b0;
        par_waddr  = r_cur;
        par_wdata  = r_root;
        rank_we    = 1'b0;
        rank_waddr = r_rb;
        rank_wdata = '0;
        fin        = 1'b0;
        fin_root   = r_root;
        fin_rank   = r_rkroot;
        o_ready    = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                par_we     = 1'b1;
                par_waddr  = r_clr;
                par_wdata  = r_clr;
                rank_we    = 1'b1;
                rank_waddr = r_clr;
                rank_wdata = '0;
                if (r_clr == LAST_NODE) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + NODE_W'(1);
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_b    = i_to_node;
                    n_cost = i_edge_cost;
                    n_acc  = 1'b0;
                    n_bad  = bad_in;
                    if (bad_in || done_now) begin
                        n_state = S_PUSH;
                    end else begin
                        ram_raddr = i_from_node;
                        n_cur     = i_from_node;
                        n_start   = i_from_node;
                        n_deep    = 1'b0;
                        n_phase   = 1'b0;
                        n_state   = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (q_par == r_cur) begin
                    n_root   = r_cur;
                    n_rkroot = q_rank;
                    if (r_deep) begin
                        // Path has two or more links: point each node at the root.
                        ram_raddr = r_start;
                        n_cur     = r_start;
                        n_state   = S_COMP;
                    end else begin
                        fin      = 1'b1;
                        fin_root = r_cur;
                        fin_rank = q_rank;
                    end
                end else begin
                    ram_raddr = q_par;
                    n_cur     = q_par;
                    if (r_cur != r_start) begin
                        n_deep = 1'b1;
                    end
                end
            end
            S_COMP: begin
                par_we    = 1'b1;
                par_waddr = r_cur;
                par_wdata = r_root;
                if (q_par == r_root) begin
                    fin = 1'b1;
                end else begin
                    ram_raddr = q_par;
                    n_cur     = q_par;
                end
            end
            S_UNION: begin
                n_state = S_PUSH;
                if (r_ra != r_rb) begin
                    n_acc   = 1'b1;
                    n_count = r_count + NODE_W'(1);
                    n_sum   = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
                    par_we  = 1'b1;
                    if (r_rka > r_rkb) begin
                        par_waddr = r_rb;
                        par_wdata = r_ra;
                    end else begin
                        par_waddr = r_ra;
                        par_wdata = r_rb;
                        if (r_rka == r_rkb && r_rkb != RANK_MAX) begin
                            rank_we    = 1'b1;
                            rank_waddr = r_rb;
                            rank_wdata = r_rkb + RANK_W'(1);
                        end
                    end
                end
            end
            S_PUSH: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A root find has ended: either start the second endpoint or join.
        if (fin) begin
            if (!r_phase) begin
                n_ra      = fin_root;
                n_rka     = fin_rank;
                ram_raddr = r_b;
                n_cur     = r_b;
                n_start   = r_b;
                n_deep    = 1'b0;
                n_phase   = 1'b1;
                n_state   = S_FIND;
            end else begin
                n_rb    = fin_root;
                n_rkb   = fin_rank;
                n_state = S_UNION;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b      <= n_b;
        r_cost   <= n_cost;
        r_cur    <= n_cur;
        r_start  <= n_start;
        r_root   <= n_root;
        r_rkroot <= n_rkroot;
        r_deep   <= n_deep;
        r_phase  <= n_phase;
        r_ra     <= n_ra;
        r_rka    <= n_rka;
        r_rb     <= n_rb;
        r_rkb    <= n_rkb;
        r_acc    <= n_acc;
        r_bad    <= n_bad;
    end

    assign o_flags.accepted  = r_acc;
    assign o_flags.tree_done = done_now;
    assign o_flags.bad_node  = r_bad;
    assign o_edges           = r_count;
    assign o_total           = r_sum;
endmodule

// File: hdl/kruskal_edge_union_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kruskal edge union-find
// Accepts cost-sorted edges and decides which ones enter the spanning tree.
// ----------------------------------------------------------------------------
// Usage:
//   Edges arrive on the i_edge request channel, already in ascending cost
//   order. Each edge yields one result request on o_res carrying the verdict
//   (accepted, tree_done, bad_node) and the running edge count and cost sum.
//   vertex_count is written through the APB port at byte address 0 while the
//   block is idle; values above MAX_NODES act as MAX_NODES.
// Sequence:
//   An edge with a bad node, or one arriving after the tree is complete,
//   goes straight to the result state, and its result is registered in the
//   output register. Otherwise the walker finds the root of each endpoint,
//   following one parent link per cycle. It compresses a find path of two or
//   more links by pointing each non-root node on it at the root, and then
//   joins the two sets. The single read port of the parent memory sets this
//   pace. A new edge is taken only once the walker is back in idle.
// Reset:
//   After reset the block sweeps the parent and rank memories, one entry a
//   cycle; i_edge.ready stays low until it finishes.
// Stalls:
//   The result sits in an output register; the next edge is taken while it
//   waits, and the walker holds its following result until o_res drains.
// ----------------------------------------------------------------------------
module kruskal_edge_union_find #(
    parameter int MAX_NODES = 1024,
    parameter int COST_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    keuf_edge_if.sink    i_edge,
    keuf_res_if.source   o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import keuf_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);

    logic [VC_W-1:0]   r_vcount;
    logic [CNT_W-1:0]  vcount_eff;
    logic              cfg_write;

    logic              w_ready;
    logic              w_start;
    logic              w_res_valid;
    logic              w_load;
    t_res_flags        w_flags;
    logic [NODE_W-1:0] w_edges;
    logic [SUM_W-1:0]  w_total;

    logic              r_ovalid;
    t_res_flags        r_oflags;
    logic [NODE_W-1:0] r_oedges;
    logic [SUM_W-1:0]  r_ototal;

    // Configuration port: one register, written in the APB access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata    = (paddr[2] == REG_VERTEX_COUNT) ? 32'(r_vcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VC_RESET;
        end else if (cfg_write) begin
            r_vcount <= pwdata[VC_W-1:0];
        end
    end

    assign vcount_eff = (32'(r_vcount) > 32'(MAX_NODES)) ? CNT_MAX : CNT_W'(r_vcount);

    assign i_edge.ready = w_ready;
    assign w_start      = i_edge.valid && w_ready;

    keuf_walker #(.MAX_NODES(MAX_NODES), .COST_BITS(COST_BITS)) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .o_ready    (w_ready),
        .i_from_node(i_edge.from_node),
        .i_to_node  (i_edge.to_node),
        .i_edge_cost(i_edge.edge_cost),
        .i_vcount   (vcount_eff),
        .o_res_valid(w_res_valid),
        .i_res_take (w_load),
        .o_flags    (w_flags),
        .o_edges    (w_edges),
        .o_total    (w_total)
    );

    // Output register: load when empty or when the held result leaves now.
    assign w_load = w_res_valid && (!r_ovalid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oflags <= w_flags;
            r_oedges <= w_edges;
            r_ototal <= w_total;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.accepted      = r_oflags.accepted;
    assign o_res.tree_done     = r_oflags.tree_done;
    assign o_res.bad_node      = r_oflags.bad_node;
    assign o_res.edges_in_tree = r_oedges;
    assign o_res.total_cost    = r_ototal;

    // An edge with a bad endpoint never enters the tree.
    a_bad_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(w_flags.accepted && w_flags.bad_node))
        else $error("bad edge reported as accepted");

    // The walker never offers a result while it is taking a new edge.
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !w_ready)
        else $error("walker ready while holding a result");

    // An accepted edge always leaves a nonzero edge count behind it.
    a_count_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_flags.accepted |=> r_oedges != '0)
        else $error("accepted edge with zero edge count");
endmodule
